FILE: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the oblique sphere rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OSR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("osr assertion failed");
`define OSR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("osr assertion failed");
`else
`define OSR_ASSERT(lbl, clk, rstn, prop)
`define OSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: src/osr_pkg.sv
// Package with constants, register indexes and CORDIC table functions for the rotation block.
package osr_pkg;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int TRIG_FRAC_DEF  = 30;
  localparam int IQ             = 58;
  localparam int NSTEP          = 60;
  localparam int SQ_STEPS       = 61;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLE_SINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_COSINE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_OFFSET = 2'd2;

  localparam logic [63:0] PI_QUARTER_Q64 = 64'hC90F_DAA2_2168_C234;

  typedef logic signed [63:0] word_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[63:0], n[j]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] udiv_shift(input logic [63:0] num, input logic [63:0] den,
                                             input int steps);
    logic [64:0] rem;
    logic [63:0] q;
    rem = {1'b0, num};
    q   = '0;
    for (int j = 0; j < steps; j++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt_fn(input logic [63:0] v);
    logic [127:0] rr;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  cand;
    rr = {64'b0, v} << IQ;
    r  = '0;
    for (int b = 60; b >= 0; b--) begin
      cand = r | (64'(1) << b);
      sq   = {64'b0, cand} * {64'b0, cand};
      if (sq <= rr) begin
        r = cand;
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] arc_fn(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = '0;
    if (i == 0) begin
      return 64'(1) << 61;
    end
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 62) begin
        term = udiv(64'(1) << (62 - e), 64'(2 * k + 1));
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return udiv_shift(acc, PI_QUARTER_Q64 >> 1, 62);
  endfunction

  function automatic logic [63:0] k_fn();
    logic [63:0] g2;
    g2 = 64'(1) << IQ;
    for (int i = 0; i < NSTEP; i++) begin
      if (2 * i < 64) begin
        g2 = g2 + (g2 >> (2 * i));
      end
    end
    return udiv_shift(64'(1) << IQ, isqrt_fn(g2), IQ);
  endfunction

  localparam logic [63:0] CORDIC_K = k_fn();

endpackage

FILE: src/oblique_sphere_rotation.sv
// Top level of the rotated-pole spherical coordinate transform pipeline.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_we_i                   cfg_idx_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o    req_type_i, lon_in_i, lat_in_i, missing_in_i
//   out      out        out_valid_o / out_stall_i  lon_out_o, lat_out_o, missing_out_o,
//                                                  domain_error_o
//
// One beat enters every cycle while in_stall_o is low.
// The depth is set by the two 60-step CORDIC pipelines and the 61-step square root.
// Reset clears the valid bits and sets the registers to sine 0, cosine 1, offset 0.
// A result held by out_stall_i freezes the whole pipeline and raises in_stall_o.
`include "assert_macros.svh"

module oblique_sphere_rotation #(
  parameter int ANGLE_BITS     = osr_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = osr_pkg::TRIG_FRAC_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [osr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((ANGLE_BITS > TRIG_FRAC_BITS + 2) ? ANGLE_BITS : TRIG_FRAC_BITS + 2)-1:0]
                                        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic signed [ANGLE_BITS-1:0]  lon_in_i,
  input  logic signed [ANGLE_BITS-1:0]  lat_in_i,
  input  logic                          missing_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [ANGLE_BITS-1:0]  lon_out_o,
  output logic signed [ANGLE_BITS-1:0]  lat_out_o,
  output logic                          missing_out_o,
  output logic                          domain_error_o
);

  localparam int TW       = TRIG_FRAC_BITS + 2;
  localparam int AS       = 64 - ANGLE_BITS;
  localparam int TS       = osr_pkg::IQ - TRIG_FRAC_BITS;
  localparam int LAT_SC   = osr_pkg::NSTEP + 2;
  localparam int LAT_QM   = 2;
  localparam int LAT_SQ   = osr_pkg::SQ_STEPS;
  localparam int LAT_AT   = osr_pkg::NSTEP + 1;
  localparam int LAT_SIDE = LAT_SC + 3 * LAT_QM + 1 + LAT_SQ + LAT_AT;
  localparam int SIDE_W   = 2 + 2 * ANGLE_BITS;

  localparam osr_pkg::word_t ONE      = osr_pkg::word_t'(64'(1) << osr_pkg::IQ);
  localparam osr_pkg::word_t SLACK    = osr_pkg::word_t'(64'(1) << (TS + 4));
  localparam logic [63:0]    QUARTER  = 64'(1) << 62;
  localparam logic [63:0]    HALF_LSB = 64'(1) << (63 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] Q_ANG = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                         en;
  logic signed [TW-1:0]         sine_q, cosine_q;
  logic [ANGLE_BITS-1:0]        off_q;
  logic [LAT_SIDE:0]            vld_q;
  logic                         req0_q, miss0_q;
  logic [ANGLE_BITS-1:0]        lon0_q, lat0_q;
  logic [63:0]                  off64, a_lon, a_lat;
  osr_pkg::word_t               ps, pc;
  osr_pkg::word_t               sl, cl, sp, cp, sp_d, cpcl, yv, y_d;
  osr_pkg::word_t               t_pscl, t_pcsp, t_pssp, t_pccl;
  logic                         req_d;
  osr_pkg::word_t               xs_q, ss_q, ys_q;
  logic                         sat_pos, sat_neg, err;
  logic [2:0]                   flags_d;
  osr_pkg::word_t               sq, c2;
  logic [63:0]                  root;
  logic [191:0]                 vec_d;
  logic [63:0]                  zlat, zlon, zlon_off, zlat_sel, lon_rnd, lat_rnd;
  logic [SIDE_W-1:0]            side_d;
  logic                         out_valid_q;
  logic [ANGLE_BITS-1:0]        lon_out_q, lat_out_q;
  logic                         miss_out_q, err_out_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sine_q   <= '0;
      cosine_q <= TW'(1) << TRIG_FRAC_BITS;
      off_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        osr_pkg::CFG_POLE_SINE:   sine_q   <= cfg_data_i[TW-1:0];
        osr_pkg::CFG_POLE_COSINE: cosine_q <= cfg_data_i[TW-1:0];
        osr_pkg::CFG_POLE_OFFSET: off_q    <= cfg_data_i[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_SIDE-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      req0_q  <= req_type_i;
      miss0_q <= missing_in_i;
      lon0_q  <= lon_in_i;
      lat0_q  <= lat_in_i;
    end
  end

  assign ps    = osr_pkg::word_t'(64'(sine_q) <<< TS);
  assign pc    = osr_pkg::word_t'(64'(cosine_q) <<< TS);
  assign off64 = 64'(off_q) << AS;
  assign a_lon = (64'(lon0_q) << AS) - (req0_q ? off64 : 64'b0);
  assign a_lat = 64'(lat0_q) << AS;

  osr_sincos u_sc_lon (.clk_i, .en_i(en), .angle_i(a_lon), .sin_o(sl), .cos_o(cl));
  osr_sincos u_sc_lat (.clk_i, .en_i(en), .angle_i(a_lat), .sin_o(sp), .cos_o(cp));

  osr_qmul u_m_cpcl (.clk_i, .en_i(en), .a_i(cp), .b_i(cl), .p_o(cpcl));
  osr_qmul u_m_cpsl (.clk_i, .en_i(en), .a_i(cp), .b_i(sl), .p_o(yv));

  osr_delay #(.W(64), .DEPTH(LAT_QM)) u_d_sp (
    .clk_i, .en_i(en), .data_i(64'(sp)), .data_o(sp_d)
  );

  osr_qmul u_m_pscl (.clk_i, .en_i(en), .a_i(ps), .b_i(cpcl), .p_o(t_pscl));
  osr_qmul u_m_pcsp (.clk_i, .en_i(en), .a_i(pc), .b_i(sp_d), .p_o(t_pcsp));
  osr_qmul u_m_pssp (.clk_i, .en_i(en), .a_i(ps), .b_i(sp_d), .p_o(t_pssp));
  osr_qmul u_m_pccl (.clk_i, .en_i(en), .a_i(pc), .b_i(cpcl), .p_o(t_pccl));

  osr_delay #(.W(64), .DEPTH(LAT_QM)) u_d_y (
    .clk_i, .en_i(en), .data_i(64'(yv)), .data_o(y_d)
  );
  osr_delay #(.W(1), .DEPTH(LAT_SC + 2 * LAT_QM)) u_d_req (
    .clk_i, .en_i(en), .data_i(req0_q), .data_o(req_d)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      xs_q <= req_d ? (t_pscl - t_pcsp) : (t_pscl + t_pcsp);
      ss_q <= req_d ? (t_pssp + t_pccl) : (t_pssp - t_pccl);
      ys_q <= y_d;
    end
  end

  assign sat_pos = (ss_q >= ONE);
  assign sat_neg = (ss_q <= -ONE);
  assign err     = sat_pos ? ((ss_q - ONE) > SLACK)
                 : sat_neg ? ((-ONE - ss_q) > SLACK) : 1'b0;

  osr_delay #(.W(3), .DEPTH(LAT_QM + LAT_SQ + LAT_AT)) u_d_flags (
    .clk_i, .en_i(en), .data_i({sat_pos, sat_neg, err}), .data_o(flags_d)
  );

  osr_qmul u_m_ss (.clk_i, .en_i(en), .a_i(ss_q), .b_i(ss_q), .p_o(sq));

  always_comb begin
    c2 = ONE - sq;
    if (c2[63]) begin
      c2 = '0;
    end
  end

  osr_isqrt u_sqrt (.clk_i, .en_i(en), .v_i(64'(c2)), .r_o(root));

  osr_delay #(.W(192), .DEPTH(LAT_QM + LAT_SQ)) u_d_vec (
    .clk_i, .en_i(en), .data_i({64'(ss_q), 64'(xs_q), 64'(ys_q)}), .data_o(vec_d)
  );

  osr_atan2 u_at_lat (
    .clk_i, .en_i(en), .y_i(osr_pkg::word_t'(vec_d[191:128])),
    .x_i(osr_pkg::word_t'(root)), .z_o(zlat)
  );
  osr_atan2 u_at_lon (
    .clk_i, .en_i(en), .y_i(osr_pkg::word_t'(vec_d[63:0])),
    .x_i(osr_pkg::word_t'(vec_d[127:64])), .z_o(zlon)
  );

  osr_delay #(.W(SIDE_W), .DEPTH(LAT_SIDE)) u_d_side (
    .clk_i, .en_i(en), .data_i({req0_q, miss0_q, lon0_q, lat0_q}), .data_o(side_d)
  );

  assign zlon_off = zlon + (side_d[SIDE_W-1] ? 64'b0 : off64);
  assign zlat_sel = flags_d[2] ? QUARTER : flags_d[1] ? (64'b0 - QUARTER) : zlat;
  assign lon_rnd  = zlon_off + HALF_LSB;
  assign lat_rnd  = zlat_sel + HALF_LSB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[LAT_SIDE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side_d[SIDE_W-2]) begin
        lon_out_q  <= side_d[2*ANGLE_BITS-1:ANGLE_BITS];
        lat_out_q  <= side_d[ANGLE_BITS-1:0];
        miss_out_q <= 1'b1;
        err_out_q  <= 1'b0;
      end else begin
        lon_out_q  <= lon_rnd[63:AS];
        lat_out_q  <= lat_rnd[63:AS];
        miss_out_q <= 1'b0;
        err_out_q  <= flags_d[0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lon_out_o      = lon_out_q;
  assign lat_out_o      = lat_out_q;
  assign missing_out_o  = miss_out_q;
  assign domain_error_o = err_out_q;

  // The input side stalls only while a finished beat waits at the output.
  `OSR_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))
  // A beat at the pipeline tail reaches the output register on the next advance.
  `OSR_ASSERT(a_tail_to_out, clk_i, rst_ni, (en && vld_q[LAT_SIDE]) |=> out_valid_o)
  // A passed-through missing point never reports a domain error.
  `OSR_ASSERT(a_miss_no_err, clk_i, rst_ni,
              (out_valid_o && missing_out_o) |-> !domain_error_o)
  // A domain error always comes with a latitude clamped to a pole.
  `OSR_ASSERT(a_err_pole, clk_i, rst_ni,
              (out_valid_o && domain_error_o) |->
              ((lat_out_o == Q_ANG) || (lat_out_o == ANGLE_BITS'(-Q_ANG))))

endmodule

FILE: src/osr_delay.sv
// Enabled shift-register line that keeps side data aligned with the pipeline.
module osr_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= data_i;
      for (int k = 1; k < DEPTH; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign data_o = pipe_q[DEPTH-1];

endmodule

FILE: src/osr_qmul.sv
// Two-stage signed Q6.58 multiplier built from four 32x32 partial products, rounded half away from zero.
module osr_qmul (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  osr_pkg::word_t        a_i,
  input  osr_pkg::word_t        b_i,
  output osr_pkg::word_t        p_o
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic         neg_q;
  logic [127:0] full;
  logic [63:0]  mag;

  assign ua = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign ub = b_i[63] ? 64'(-b_i) : 64'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= ua[31:0] * ub[31:0];
      p01_q <= ua[31:0] * ub[63:32];
      p10_q <= ua[63:32] * ub[31:0];
      p11_q <= ua[63:32] * ub[63:32];
      neg_q <= a_i[63] ^ b_i[63];
    end
  end

  assign full = {64'b0, p00_q} + ({64'b0, p01_q} << 32) + ({64'b0, p10_q} << 32)
              + {p11_q, 64'b0} + (128'(1) << (osr_pkg::IQ - 1));
  assign mag  = full[osr_pkg::IQ+63:osr_pkg::IQ];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg_q ? osr_pkg::word_t'(-mag) : osr_pkg::word_t'(mag);
    end
  end

endmodule

FILE: src/osr_sincos.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a 64-bit binary angle.
module osr_sincos (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [63:0]    angle_i,
  output osr_pkg::word_t sin_o,
  output osr_pkg::word_t cos_o
);

  localparam int N = osr_pkg::NSTEP;

  osr_pkg::word_t x_q [N+1];
  osr_pkg::word_t y_q [N+1];
  osr_pkg::word_t z_q [N+1];
  logic [1:0]     qd_q [N+1];
  logic [1:0]     quad;

  assign quad = 2'(angle_i[63:62] + 2'(angle_i[61]));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= osr_pkg::CORDIC_K;
      y_q[0]  <= '0;
      z_q[0]  <= osr_pkg::word_t'(angle_i - {quad, 62'b0});
      qd_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam osr_pkg::word_t ARC = osr_pkg::word_t'(osr_pkg::arc_fn(i));
    osr_pkg::word_t dx;
    osr_pkg::word_t dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_q[i+1] <= qd_q[i];
        if (!z_q[i][63]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ARC;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ARC;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (qd_q[N])
        2'd0: begin
          cos_o <= x_q[N];
          sin_o <= y_q[N];
        end
        2'd1: begin
          cos_o <= -y_q[N];
          sin_o <= x_q[N];
        end
        2'd2: begin
          cos_o <= -x_q[N];
          sin_o <= -y_q[N];
        end
        default: begin
          cos_o <= y_q[N];
          sin_o <= -x_q[N];
        end
      endcase
    end
  end

endmodule

FILE: src/osr_atan2.sv
// Pipelined vectoring-mode CORDIC giving the 64-bit binary angle of a vector.
module osr_atan2 (
  input  logic           clk_i,
  input  logic           en_i,
  input  osr_pkg::word_t y_i,
  input  osr_pkg::word_t x_i,
  output logic [63:0]    z_o
);

  localparam int N = osr_pkg::NSTEP;

  osr_pkg::word_t x_q [N+1];
  osr_pkg::word_t y_q [N+1];
  logic [63:0]    z_q [N+1];
  logic           zf_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zf_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[63]) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= 64'(1) << 63;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic [63:0] ARC = osr_pkg::arc_fn(i);
    osr_pkg::word_t dx;
    osr_pkg::word_t dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zf_q[i+1] <= zf_q[i];
        if (!y_q[i][63]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ARC;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ARC;
        end
      end
    end
  end

  assign z_o = zf_q[N] ? '0 : z_q[N];

endmodule

FILE: src/osr_isqrt.sv
// Pipelined restoring square root, one result bit per stage, of a Q6.58 value.
module osr_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] v_i,
  output logic [63:0] r_o
);

  localparam int S = osr_pkg::SQ_STEPS;

  logic [121:0] rem_c  [S];
  logic [S-1:0] root_c [S];
  logic [121:0] rem_q  [S];
  logic [S-1:0] root_q [S];

  assign rem_c[0]  = 122'(v_i) << osr_pkg::IQ;
  assign root_c[0] = '0;

  for (genvar j = 0; j < S; j++) begin : g_bit
    localparam int B = S - 1 - j;
    logic [121:0] trial;
    assign trial = (122'(root_c[j]) << (B + 1)) + (122'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_c[j] >= trial) begin
          rem_q[j]  <= rem_c[j] - trial;
          root_q[j] <= root_c[j] | (S'(1) << B);
        end else begin
          rem_q[j]  <= rem_c[j];
          root_q[j] <= root_c[j];
        end
      end
    end
    if (j < S - 1) begin : g_next
      assign rem_c[j+1]  = rem_q[j];
      assign root_c[j+1] = root_q[j];
    end
  end

  assign r_o = 64'(root_q[S-1]);

endmodule
